/* sv/bm3_pkg.sv */
package bm3_pkg;

    localparam int PIXEL_W      = 8;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_ADDR_W   = 1;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(512);
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(512);
    localparam int MIN_DIM = 3;

    localparam int CSUM_W = 10;
    localparam int SUM_W  = 12;

    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'(7282);
    localparam int PROD_W = SUM_W + RECIP_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] top;
        logic [PIXEL_W-1:0] mid;
        logic [PIXEL_W-1:0] bot;
        logic               emit_a;
        logic               emit_b;
        logic               mirror;
        logic               last;
    } col_entry_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] mean;
        logic               last;
    } result_t;

endpackage

/* sv/box_mean_3x3_mirror_border_core.sv */
// 3x3 box mean filter with mirrored borders for 8-bit grey frames.
// Input queue: drive pixel_in with push high; a transaction completes on a
// clock edge where full is low. Pixels come in raster order, frame after frame.
// Result queue: while empty is low, mean_pixel/frame_last hold the oldest
// result; pop high on a clock edge takes it. frame_last marks the final pixel.
// Output row r-1 leaves while input row r arrives; the last row of a frame
// leaves while row 0 of the next frame comes in. Each pixel accepted gives
// zero, one or two results (two at the end of a row).
// Throughput: one pixel per cycle inside a row while no queue is full; the two
// end-of-row results leave the sum stage one after the other, so a row takes
// longer than its pixels and the column queue soaks up the extra time only
// for a few rows. A result reaches the result ports through the line store read
// with staging, the column queue, the sum register and the result queue; the
// second end-of-row result follows it unless the result queue is full.
// A stalled receiver fills the result queue, then the column queue, then
// raises full; nothing is lost. Reset empties both queues, restarts the frame
// and sets width and height to 512. A register write also restarts the frame.
module box_mean_3x3_mirror_border_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [bm3_pkg::PIXEL_W-1:0]    pixel_in,
    input  logic                           pop,
    output logic                           empty,
    output logic [bm3_pkg::PIXEL_W-1:0]    mean_pixel,
    output logic                           frame_last,
    input  logic                           cfg_wr_en,
    input  logic [bm3_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bm3_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import bm3_pkg::*;

    col_entry_t col_wr_data, col_rd_data;
    logic       col_wr_en, col_full, col_rd_en, col_empty;
    result_t    res_wr_data, res_rd_data;
    logic       res_wr_en, res_full;

    bm3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel_in  (pixel_in),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_wr_en   (col_wr_en),
        .q_wr_data (col_wr_data),
        .q_full    (col_full)
    );

    bm3_fifo #(
        .DATA_W ($bits(col_entry_t))
    ) u_col_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (col_wr_en),
        .wr_data (col_wr_data),
        .full    (col_full),
        .rd_en   (col_rd_en),
        .rd_data (col_rd_data),
        .empty   (col_empty)
    );

    bm3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (col_empty),
        .q_rd_data (col_rd_data),
        .q_rd_en   (col_rd_en),
        .o_wr_en   (res_wr_en),
        .o_wr_data (res_wr_data),
        .o_full    (res_full)
    );

    bm3_fifo #(
        .DATA_W ($bits(result_t))
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr_en),
        .wr_data (res_wr_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

    assign mean_pixel = res_rd_data.mean;
    assign frame_last = res_rd_data.last;

endmodule

/* sv/bm3_fifo.sv */
module bm3_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              empty
);
    import bm3_pkg::*;

    logic [DATA_W-1:0]      mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_wr, do_rd;

    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* sv/bm3_front.sv */
module bm3_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [bm3_pkg::PIXEL_W-1:0]          pixel_in,
    input  logic                                 cfg_wr_en,
    input  logic [bm3_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [bm3_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    output logic                                 q_wr_en,
    output bm3_pkg::col_entry_t                  q_wr_data,
    input  logic                                 q_full
);
    import bm3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int WC = (WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W;
    localparam int HC = (HW > CFG_HEIGHT_W) ? HW : CFG_HEIGHT_W;

    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [WC-1:0]           width_ext;
    logic [HC-1:0]           height_ext;
    logic [WW-1:0]           w_eff;
    logic [HW-1:0]           h_eff;

    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          tail_reg, tail_next;

    logic [2*PIXEL_W-1:0] line_store_reg [MAX_WIDTH];
    logic [2*PIXEL_W-1:0] rd_data_reg;

    logic               s1_valid_reg, s1_valid_next;
    logic [AW-1:0]      s1_col_reg;
    logic [PIXEL_W-1:0] s1_px_reg;
    logic               s1_row0_reg, s1_row1_reg;
    logic               s1_emit_a_reg, s1_emit_b_reg, s1_mirror_reg;

    logic               accept;
    logic               row_end, frame_end, emit;
    logic [PIXEL_W-1:0] up, lo;

    always_comb
    begin
        width_ext  = WC'(width_reg);
        height_ext = HC'(height_reg);
        if (width_ext < WC'(MIN_DIM))
        begin
            w_eff = WW'(MIN_DIM);
        end
        else if (width_ext > WC'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_ext);
        end
        if (height_ext < HC'(MIN_DIM))
        begin
            h_eff = HW'(MIN_DIM);
        end
        else if (height_ext > HC'(MAX_HEIGHT))
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HW'(height_ext);
        end
    end

    assign q_wr_en = s1_valid_reg && !q_full;
    assign full    = s1_valid_reg && q_full;
    assign accept  = push && !full;

    assign row_end   = (WW'(col_reg) == w_eff - WW'(1));
    assign frame_end = (HW'(row_reg) == h_eff - HW'(1));
    assign emit      = (row_reg != '0) || tail_reg;

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        tail_next     = tail_reg;
        s1_valid_next = s1_valid_reg;
        if (q_wr_en)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
            if (row_end)
            begin
                col_next = '0;
                if (frame_end)
                begin
                    row_next  = '0;
                    tail_next = 1'b1;
                end
                else
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
        if (cfg_wr_en)
        begin
            col_next  = '0;
            row_next  = '0;
            tail_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            tail_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            tail_reg     <= tail_next;
            s1_valid_reg <= s1_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_IMAGE_WIDTH:  width_reg  <= CFG_WIDTH_W'(cfg_wdata);
                    REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg   <= line_store_reg[col_reg];
            s1_col_reg    <= col_reg;
            s1_px_reg     <= pixel_in;
            s1_row0_reg   <= (row_reg == '0);
            s1_row1_reg   <= (row_reg == RW'(1));
            s1_emit_a_reg <= emit && (col_reg != '0);
            s1_emit_b_reg <= emit && row_end;
            s1_mirror_reg <= (col_reg == AW'(1));
        end
        if (q_wr_en)
        begin
            line_store_reg[s1_col_reg] <= {lo, s1_px_reg};
        end
    end

    assign up = rd_data_reg[2*PIXEL_W-1:PIXEL_W];
    assign lo = rd_data_reg[PIXEL_W-1:0];

    always_comb
    begin
        q_wr_data.mid    = lo;
        q_wr_data.emit_a = s1_emit_a_reg;
        q_wr_data.emit_b = s1_emit_b_reg;
        q_wr_data.mirror = s1_mirror_reg;
        q_wr_data.last   = s1_row0_reg;
        if (s1_row0_reg)
        begin
            q_wr_data.top = up;
            q_wr_data.bot = up;
        end
        else if (s1_row1_reg)
        begin
            q_wr_data.top = s1_px_reg;
            q_wr_data.bot = s1_px_reg;
        end
        else
        begin
            q_wr_data.top = up;
            q_wr_data.bot = s1_px_reg;
        end
    end

endmodule

/* sv/bm3_back.sv */
module bm3_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  bm3_pkg::col_entry_t q_rd_data,
    output logic                q_rd_en,
    output logic                o_wr_en,
    output bm3_pkg::result_t    o_wr_data,
    input  logic                o_full
);
    import bm3_pkg::*;

    logic [CSUM_W-1:0] cs0_reg, cs1_reg, cs2;
    logic [SUM_W-1:0]  sum_a_reg, sum_b_reg, sum_sel;
    logic              pend_a_reg, pend_a_next;
    logic              pend_b_reg, pend_b_next;
    logic              last_reg;
    logic              busy, done;
    logic [PROD_W-1:0] prod;

    assign busy    = pend_a_reg || pend_b_reg;
    assign o_wr_en = busy && !o_full;
    assign done    = o_wr_en && !(pend_a_reg && pend_b_reg);
    assign q_rd_en = !q_empty && (!busy || done);

    assign cs2 = CSUM_W'(q_rd_data.top) + CSUM_W'(q_rd_data.mid) + CSUM_W'(q_rd_data.bot);

    always_comb
    begin
        pend_a_next = pend_a_reg;
        pend_b_next = pend_b_reg;
        if (o_wr_en)
        begin
            if (pend_a_reg)
            begin
                pend_a_next = 1'b0;
            end
            else
            begin
                pend_b_next = 1'b0;
            end
        end
        if (q_rd_en)
        begin
            pend_a_next = q_rd_data.emit_a;
            pend_b_next = q_rd_data.emit_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_a_reg <= 1'b0;
            pend_b_reg <= 1'b0;
        end
        else
        begin
            pend_a_reg <= pend_a_next;
            pend_b_reg <= pend_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd_en)
        begin
            cs0_reg   <= cs1_reg;
            cs1_reg   <= cs2;
            sum_a_reg <= SUM_W'(q_rd_data.mirror ? cs2 : cs0_reg) + SUM_W'(cs1_reg)
                         + SUM_W'(cs2);
            sum_b_reg <= SUM_W'({cs1_reg, 1'b0}) + SUM_W'(cs2);
            last_reg  <= q_rd_data.last;
        end
    end

    assign sum_sel = pend_a_reg ? sum_a_reg : sum_b_reg;
    assign prod    = PROD_W'(sum_sel) * PROD_W'(RECIP_NINE);

    assign o_wr_data.mean = prod[RECIP_SHIFT+PIXEL_W-1:RECIP_SHIFT];
    assign o_wr_data.last = !pend_a_reg && last_reg;

endmodule

/* test/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bm3_pkg::*;

    localparam int MAX_W          = 1024;
    localparam int MAX_H          = 4096;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef enum int {
        STYLE_RANDOM,
        STYLE_WHITE,
        STYLE_BLACK,
        STYLE_EXTREME
    } pixel_style_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  push       = 1'b0;
    logic                  full;
    logic [PIXEL_W-1:0]    pixel_in   = '0;
    logic                  pop        = 1'b0;
    logic                  empty;
    logic [PIXEL_W-1:0]    mean_pixel;
    logic                  frame_last;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr   = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

    box_mean_3x3_mirror_border_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel_in   (pixel_in),
        .pop        (pop),
        .empty      (empty),
        .mean_pixel (mean_pixel),
        .frame_last (frame_last),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    always #4 clk = ~clk;

    // filter state as seen from outside
    logic [PIXEL_W-1:0]      upper_row [MAX_W] = '{default: '0};
    logic [PIXEL_W-1:0]      lower_row [MAX_W] = '{default: '0};
    logic [PIXEL_W-1:0]      window [9]        = '{default: '0};
    int unsigned             row_idx           = 0;
    int unsigned             col_idx           = 0;
    bit                      tail_pending      = 1'b0;
    logic [CFG_WIDTH_W-1:0]  frame_width       = WIDTH_RESET;
    logic [CFG_HEIGHT_W-1:0] frame_height      = HEIGHT_RESET;

    result_t                 mean_queue [$];
    logic [PIXEL_W-1:0]      pixels_pending [$];

    int  mismatches  = 0;
    int  quiet       = 0;
    bit  calm        = 1'b0;
    int  holds_asked = 0;
    int  holds_done  = 0;
    int  rx_hold     = 0;
    int  rx_gap      = 0;
    int  tx_gap      = 0;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int unsigned column_sum(int k);
        return int'(window[3*k]) + int'(window[3*k+1]) + int'(window[3*k+2]);
    endfunction

    function automatic logic [PIXEL_W-1:0] pick_pixel(pixel_style_t style);
        case (style)
            STYLE_WHITE:   return '1;
            STYLE_BLACK:   return '0;
            STYLE_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
            default:       return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pixel_style_t pick_style();
        case ($urandom_range(0, 7))
            0:       return STYLE_WHITE;
            1:       return STYLE_BLACK;
            2:       return STYLE_EXTREME;
            default: return STYLE_RANDOM;
        endcase
    endfunction

    task automatic filter_pixel(input logic [PIXEL_W-1:0] px);
        int unsigned        w, h, c, r, s;
        int                 i;
        logic [PIXEL_W-1:0] t, m, b;
        bit                 emit;
        result_t            res;
        w = clamp_dim(32'(frame_width), MAX_W);
        h = clamp_dim(32'(frame_height), MAX_H);
        if (col_idx >= w)
            col_idx = 0;
        if (row_idx >= h)
            row_idx = 0;
        c = col_idx;
        r = row_idx;
        m = lower_row[c];
        if (r == 0)
        begin
            t = upper_row[c];
            b = upper_row[c];
        end
        else if (r == 1)
        begin
            t = px;
            b = px;
        end
        else
        begin
            t = upper_row[c];
            b = px;
        end
        for (i = 0; i < 6; i++)
            window[i] = window[i+3];
        window[6] = t;
        window[7] = m;
        window[8] = b;
        emit = (r != 0) || tail_pending;
        if (emit && c >= 1)
        begin
            s = (c == 1 ? column_sum(2) : column_sum(0)) + column_sum(1) + column_sum(2);
            res.mean = PIXEL_W'(s / 9);
            res.last = 1'b0;
            mean_queue.push_back(res);
        end
        if (emit && c == w - 1)
        begin
            s = 2 * column_sum(1) + column_sum(2);
            res.mean = PIXEL_W'(s / 9);
            res.last = (r == 0);
            mean_queue.push_back(res);
        end
        upper_row[c] = m;
        lower_row[c] = px;
        if (c + 1 >= w)
        begin
            col_idx = 0;
            if (r + 1 >= h)
            begin
                row_idx      = 0;
                tail_pending = 1'b1;
            end
            else
                row_idx = r + 1;
        end
        else
            col_idx = c + 1;
    endtask

    task automatic wait_idle();
        while (pixels_pending.size() != 0 || mean_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_pixels(input int count, input pixel_style_t style);
        repeat (count) pixels_pending.push_back(pick_pixel(style));
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n || pixels_pending.size() == 0)
            push <= 1'b0;
        else if (tx_gap > 0)
        begin
            push <= 1'b0;
            tx_gap--;
        end
        else if (!calm && $urandom_range(0, 15) == 0)
        begin
            push   <= 1'b0;
            tx_gap = $urandom_range(0, 15);
        end
        else
        begin
            push     <= 1'b1;
            pixel_in <= pixels_pending[0];
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (holds_done != holds_asked)
        begin
            pop     <= 1'b0;
            rx_hold = HOLD_CYCLES;
            holds_done++;
        end
        else if (rx_hold > 0)
        begin
            pop <= 1'b0;
            rx_hold--;
        end
        else if (rx_gap > 0)
        begin
            pop <= 1'b0;
            rx_gap--;
        end
        else if (!calm && $urandom_range(0, 15) == 0)
        begin
            pop    <= 1'b0;
            rx_gap = $urandom_range(0, 15);
        end
        else
            pop <= 1'b1;
    end

    // monitor, predictor update and watchdog
    always @(posedge clk)
    begin
        result_t want;
        bit      busy;
        busy = 1'b0;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                busy = 1'b1;
                if (mean_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("[%0t] unexpected result mean %0d last %0b", $time,
                                 mean_pixel, frame_last);
                end
                else
                begin
                    want = mean_queue.pop_front();
                    if (mean_pixel !== want.mean || frame_last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("[%0t] mismatch: expected mean %0d last %0b, got mean %0d last %0b",
                                     $time, want.mean, want.last, mean_pixel, frame_last);
                    end
                end
            end
            if (cfg_wr_en)
            begin
                busy = 1'b1;
                case (cfg_reg_t'(cfg_addr))
                    REG_IMAGE_WIDTH:  frame_width  = cfg_wdata[CFG_WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT: frame_height = cfg_wdata[CFG_HEIGHT_W-1:0];
                    default: ;
                endcase
                row_idx      = 0;
                col_idx      = 0;
                tail_pending = 1'b0;
            end
            if (push && !full)
            begin
                busy = 1'b1;
                filter_pixel(pixel_in);
                void'(pixels_pending.pop_front());
            end
            if (busy)
                quiet = 0;
            else
            begin
                quiet++;
                if (quiet >= WATCHDOG_LIMIT)
                begin
                    $display("** box_mean_3x3_mirror_border_core: FAILED **");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int w, h, n;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // smallest frame: silent first row, tail flushed by the next frame
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
        send_pixels(9, STYLE_WHITE);
        send_pixels(9, STYLE_BLACK);
        send_pixels(3, STYLE_EXTREME);

        // saturation below the range, pending tail dropped by the write
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(0));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(1));
        send_pixels(21, STYLE_RANDOM);

        for (int p = 0; p < 8; p++)
        begin
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
            if (p == 0 || $urandom_range(0, 1) == 1)
                write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
            else
                h = int'(clamp_dim(32'(frame_height), MAX_H));
            n = $urandom_range(w * h / 2, w * h + w);
            if (p == 3)
            begin
                holds_asked++;
                send_pixels(2 * w * h + w, pick_style());
            end
            else if (p == 6)
            begin
                send_pixels(n / 2, pick_style());
                wait_idle();
                send_pixels(n - n / 2, pick_style());
            end
            else
                send_pixels(n, pick_style());
        end

        // no idling from here on
        wait_idle();
        calm = 1'b1;
        w = $urandom_range(3, 16);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
        send_pixels(7 * w, STYLE_RANDOM);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && mean_queue.size() == 0)
            $display("** box_mean_3x3_mirror_border_core: PASSED **");
        else
            $display("** box_mean_3x3_mirror_border_core: FAILED **");
        $finish;
    end

endmodule

/* box_mean_3x3_mirror_border_core.f */
sv/bm3_pkg.sv
sv/bm3_fifo.sv
sv/bm3_front.sv
sv/bm3_back.sv
sv/box_mean_3x3_mirror_border_core.sv
test/testbench.sv
